[hw/rtl/bounded_deque_with_search_macros.svh]
// ----------------------------------------------------------------------------
// bounded_deque_with_search_macros.svh
// assertion macros for the checker file of the deque block
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BDQ_CHK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled while in reset
`define BDQ_CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[hw/rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// request codes, status codes and the word type of the deque block
// ----------------------------------------------------------------------------
package bdq_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [2:0]         req_t;
  typedef logic [1:0]         status_t;

  // request kinds
  localparam req_t REQ_INS_FRONT = 3'd0;
  localparam req_t REQ_INS_REAR  = 3'd1;
  localparam req_t REQ_REM_FRONT = 3'd2;
  localparam req_t REQ_REM_REAR  = 3'd3;
  localparam req_t REQ_SEARCH    = 3'd4;

  // result status
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_MISS  = 2'd3;

endpackage

[hw/rtl/bounded_deque_with_search.sv]
// sequence: an insert, rejected or unused request goes from accept through
//   S_DONE to the output register; a removal through S_READ, S_CHECK, S_DONE;
//   a search repeats S_READ and S_CHECK once per item compared (at most DEPTH)
// one request word at a time: the next is taken only once the previous result
//   enters the output register, and S_DONE waits while out_stall holds the
//   output register
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// double-ended queue of up to DEPTH signed words with linear key search
// reset: synchronous active-low rst_n empties the deque, store contents stay
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bdq_pkg::req_t                   in_req_type,
  input  bdq_pkg::word_t                  in_data_value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output bdq_pkg::status_t                out_status,
  output bdq_pkg::word_t                  out_removed_value,
  output logic [$clog2(DEPTH + 1)-1:0]    out_item_count
);
  import bdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // store address width
  localparam int CW = $clog2(DEPTH + 1);                // item count width

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a request word
  localparam logic [1:0] S_READ  = 2'd1;  // store read in flight
  localparam logic [1:0] S_CHECK = 2'd2;  // read data back: compare or take
  localparam logic [1:0] S_DONE  = 2'd3;  // hand result to output register

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;     // slot of the front item
  logic [CW-1:0] count_r, count_nxt;     // items held
  req_t          kind_r, kind_nxt;
  word_t         key_r, key_nxt;
  logic [AW-1:0] addr_r, addr_nxt;       // read address (scan pointer)
  logic [AW-1:0] idx_r, idx_nxt;         // scan offset from the front
  status_t       res_status_r, res_status_nxt;
  word_t         res_removed_r, res_removed_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  word_t         out_removed_r, out_removed_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;

  // store ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  word_t         rd_data;

  // shared slot adder: front + offset, wrapped into the store
  logic [CW-1:0] slot_off;
  logic [CW:0]   slot_sum;
  logic [CW:0]   slot_wrap;
  logic [AW-1:0] slot;

  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] addr_inc;
  logic          full;
  logic          empty;
  logic          scan_last;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // rear insert targets front+count, rear removal targets front+count-1
  assign slot_off  = (in_req_type == REQ_REM_REAR) ? (count_r - CW'(1)) : count_r;
  assign slot_sum  = {{(CW + 1 - AW){1'b0}}, front_r} + {1'b0, slot_off};
  assign slot_wrap = (slot_sum >= (CW + 1)'(DEPTH)) ? (slot_sum - (CW + 1)'(DEPTH))
                                                     : slot_sum;
  assign slot      = slot_wrap[AW-1:0];

  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : (front_r - AW'(1));
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : (front_r + AW'(1));
  assign addr_inc  = (addr_r == AW'(DEPTH - 1)) ? '0 : (addr_r + AW'(1));

  // last compare of a search when the next offset reaches the count
  assign scan_last = ((CW'(idx_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt       = state_r;
    front_nxt       = front_r;
    count_nxt       = count_r;
    kind_nxt        = kind_r;
    key_nxt         = key_r;
    addr_nxt        = addr_r;
    idx_nxt         = idx_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_count_nxt   = out_count_r;
    wr_en           = 1'b0;
    wr_addr         = slot;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt        = in_req_type;
          key_nxt         = in_data_value;
          idx_nxt         = '0;
          res_status_nxt  = ST_OK;
          res_removed_nxt = '0;
          state_nxt       = S_DONE;
          case (in_req_type)
            REQ_INS_FRONT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_INS_REAR: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_REM_FRONT: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                addr_nxt  = front_r;
                front_nxt = front_inc;
                count_nxt = count_r - CW'(1);
                state_nxt = S_READ;
              end
            end
            REQ_REM_REAR: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                addr_nxt  = slot;
                count_nxt = count_r - CW'(1);
                state_nxt = S_READ;
              end
            end
            REQ_SEARCH: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                addr_nxt  = front_r;
                state_nxt = S_READ;
              end
            end
            default: begin
              // unused kinds: no change, plain ok result
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (kind_r == REQ_SEARCH) begin
          if (rd_data == key_r) begin
            res_status_nxt = ST_OK;
            state_nxt      = S_DONE;
          end else if (scan_last) begin
            res_status_nxt = ST_MISS;
            state_nxt      = S_DONE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            addr_nxt  = addr_inc;
            state_nxt = S_READ;
          end
        end else begin
          // removal: read word is the removed item
          res_removed_nxt = rd_data;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_removed_nxt = res_removed_r;
          out_count_nxt   = count_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    key_r         <= key_nxt;
    addr_r        <= addr_nxt;
    idx_r         <= idx_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_count_r   <= out_count_nxt;
  end

  bdq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data_value),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  // request words only while idle and out of reset
  assign in_stall          = !rst_n || (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_item_count    = out_count_r;

endmodule

[hw/rtl/bdq_store.sv]
// ----------------------------------------------------------------------------
// bdq_store
// circular item store: one write port, one registered read port
// ----------------------------------------------------------------------------
module bdq_store #(
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  bdq_pkg::word_t                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output bdq_pkg::word_t                            rd_data
);
  import bdq_pkg::*;

  word_t mem [DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// port-level checks on the result channel of the deque block
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_macros.svh"

module bdq_checker #(
  parameter int DEPTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input bdq_pkg::status_t             out_status,
  input bdq_pkg::word_t               out_removed_value,
  input logic [$clog2(DEPTH + 1)-1:0] out_item_count
);
  import bdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  `BDQ_CHK_NOW(a_count_bound, out_valid, out_item_count <= CW'(DEPTH))
  `BDQ_CHK_NOW(a_full_count, out_valid && out_status == ST_FULL, out_item_count == CW'(DEPTH))
  `BDQ_CHK_NOW(a_empty_count, out_valid && out_status == ST_EMPTY, out_item_count == '0)
  `BDQ_CHK_NOW(a_removed_zero, out_valid && out_status != ST_OK, out_removed_value == '0)
  `BDQ_CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_removed_value) && $stable(out_item_count))

endmodule

bind bounded_deque_with_search bdq_checker #(
  .DEPTH (DEPTH)
) u_bdq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_removed_value (out_removed_value),
  .out_item_count    (out_item_count)
);
